FILE: src/min_priority_queue_unit_assert.svh
// assertion macros for the min priority queue unit
`ifndef MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// pre implies post in the same cycle
`define MPQ_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the following cycle
`define MPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/mpq_pkg.sv
// package with types and constants of the min priority queue unit
package mpq_pkg;

  localparam int KEY_W        = 32;
  localparam int TAG_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] item_key;
    logic [TAG_W-1:0]        item_tag;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic [TAG_W-1:0]        out_tag;
    logic [STATUS_W-1:0]     status;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic valid;
    rsp_t word;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } state_t;

endpackage

FILE: src/mpq_ram.sv
// generic single write, single read ram with registered read data
module mpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mpq_core.sv
// sequencer and single compare unit that keep the ram sorted by key
`include "min_priority_queue_unit_assert.svh"

module mpq_core import mpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output res_t res,
  input  logic res_take
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $bits(entry_t);

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic signed [KEY_W-1:0] cur_key, cur_key_next;
  logic [TAG_W-1:0]     cur_tag, cur_tag_next;
  logic signed [KEY_W-1:0] res_key, res_key_next;
  logic [TAG_W-1:0]     res_tag, res_tag_next;
  logic [STATUS_W-1:0]  res_status, res_status_next;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  entry_t               wdata, rdata;
  logic [EW-1:0]        rdata_raw;
  logic [CW-1:0]        idx_dec, idx_inc;
  logic                 accept, is_full, is_empty, shift_up, last_rem;

  mpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata    = entry_t'(rdata_raw);
  assign idx_dec  = idx - CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign accept   = (state == S_IDLE) && req_valid;
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);
  assign shift_up = (rdata.key >= cur_key);
  assign last_rem = (idx_inc == count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_INSERT) begin
            state_next = is_full ? S_DONE : S_INS_RD;
          end else begin
            state_next = is_empty ? S_DONE : S_REM_RD;
          end
        end
      end
      S_INS_RD:  state_next = (idx == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP: state_next = shift_up ? S_INS_RD : S_DONE;
      S_REM_RD:  state_next = S_REM_WR;
      S_REM_WR:  state_next = last_rem ? S_DONE : S_REM_RD;
      S_DONE:    state_next = res_take ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    idx_next        = idx;
    cur_key_next    = cur_key;
    cur_tag_next    = cur_tag;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = idx[AW-1:0];
    wdata           = '{key: cur_key, tag: cur_tag};
    raddr           = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_key_next = req.item_key;
          cur_tag_next = req.item_tag;
          res_key_next = '0;
          res_tag_next = '0;
          if (req.opcode == OP_INSERT) begin
            idx_next        = count;
            res_status_next = is_full ? ST_FULL : ST_INSERTED;
          end else begin
            idx_next        = '0;
            res_status_next = is_empty ? ST_EMPTY : ST_REMOVED;
          end
        end
      end
      S_INS_RD: begin
        raddr = idx_dec[AW-1:0];
        if (idx == '0) begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (shift_up) begin
          wdata    = rdata;
          idx_next = idx_dec;
        end else begin
          count_next = count + CW'(1);
        end
      end
      S_REM_RD: begin
      end
      S_REM_WR: begin
        if (idx == '0) begin
          res_key_next = rdata.key;
          res_tag_next = rdata.tag;
        end else begin
          we    = 1'b1;
          waddr = idx_dec[AW-1:0];
          wdata = rdata;
        end
        idx_next = idx_inc;
        if (last_rem) begin
          count_next = count - CW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx        <= idx_next;
    cur_key    <= cur_key_next;
    cur_tag    <= cur_tag_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
  end

  assign req_stall      = (state != S_IDLE);
  assign res.valid      = (state == S_DONE);
  assign res.word       = '{out_key: res_key, out_tag: res_tag, status: res_status};

  `MPQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "count past capacity")
  `MPQ_ASSERT_NEXT(a_empty_remove, clk, rst,
    accept && req.opcode == OP_REMOVE && is_empty,
    state == S_DONE && res_status == ST_EMPTY, "empty remove not reported")
  `MPQ_ASSERT_NOW(a_shift_index, clk, rst, state == S_INS_CMP,
    idx != '0 && idx <= count, "insert shift index out of range")
  `MPQ_ASSERT_NOW(a_no_idle_write, clk, rst, state == S_IDLE || state == S_DONE,
    !we, "ram written outside a sequence")

endmodule

FILE: src/min_priority_queue_unit.sv
// top level of the min priority queue unit with output register
//
// channel  direction  word   handshake
// req      in         req_t  req_valid / req_stall
// rsp      out        rsp_t  rsp_valid / rsp_stall
//
// ram steps of each operation, from accept until the result is taken
// insert: read and compare down to the first lower key, shift up those at or above, then write the new key
// remove: head read as the result; one ram read and write per entry moved down
// full insert and empty remove: no ram access, the status is reported directly
// rst clears the entry count; ram contents are not cleared
// the output register holds one result, so one more word is taken while rsp_stall holds

module min_priority_queue_unit import mpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  res_t res;
  logic res_take;
  logic rsp_valid_next;

  mpq_core #(.CAPACITY(CAPACITY)) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take       = !rsp_valid || !rsp_stall;
  assign rsp_valid_next = (rsp_valid && rsp_stall) || res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
    if (res.valid && res_take) begin
      rsp <= res.word;
    end
  end

endmodule
